// ===== src/boc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package boc_pkg;

    // Internal widths of the count and time registers.
    localparam int COUNT_BITS = 16;
    localparam int TIME_BITS  = 32;

    // Field widths of the words on the ports.
    localparam int DIST_W     = 10;
    localparam int LEVEL_W    = 16;
    localparam int NOW_W      = 32;
    localparam int THR_W      = 9;
    localparam int TMO_W      = 16;
    localparam int OCC_W      = 16;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_THR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd2;

    // Configuration reset values.
    localparam logic [THR_W-1:0]          DIST_THR_RST = 9'd50;
    localparam logic signed [LEVEL_W-1:0] PRES_THR_RST = 16'sd0;
    localparam logic [TMO_W-1:0]          TIMEOUT_RST  = 16'd2000;

    // Distance code for a sensor that saw no echo.
    localparam logic signed [DIST_W-1:0] NO_ECHO = -10'sd1;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_ENTER_DET  = 5'b00010,
        PH_LEAVE_DET  = 5'b00100,
        PH_ENTER_DONE = 5'b01000,
        PH_LEAVE_DONE = 5'b10000
    } t_phase;

    // Phase codes as they appear in the result word.
    localparam logic [PHASE_W-1:0] CODE_IDLE       = 3'd0;
    localparam logic [PHASE_W-1:0] CODE_ENTER_DET  = 3'd1;
    localparam logic [PHASE_W-1:0] CODE_LEAVE_DET  = 3'd2;
    localparam logic [PHASE_W-1:0] CODE_ENTER_DONE = 3'd3;
    localparam logic [PHASE_W-1:0] CODE_LEAVE_DONE = 3'd4;

    typedef struct packed {
        logic [THR_W-1:0]          dist_thr;
        logic signed [LEVEL_W-1:0] pres_thr;
        logic [TMO_W-1:0]          timeout;
    } t_cfg;

    typedef struct packed {
        t_phase                  phase;
        logic [COUNT_BITS-1:0]   count;
        logic [TIME_BITS-1:0]    mark;
        logic                    presence;
    } t_state;

    typedef struct packed {
        logic [NOW_W-1:0]          now_ms;
        logic signed [LEVEL_W-1:0] ir_level;
        logic signed [DIST_W-1:0]  leave_dist;
        logic signed [DIST_W-1:0]  enter_dist;
    } t_sample;

    typedef struct packed {
        logic                underflow_error;
        logic                exited;
        logic                entered;
        logic [PHASE_W-1:0]  phase;
        logic [OCC_W-1:0]    occupancy;
    } t_result;

    function automatic logic [PHASE_W-1:0] phase_code(input t_phase ph);
        logic [PHASE_W-1:0] code;
        case (ph)
            PH_ENTER_DET:  code = CODE_ENTER_DET;
            PH_LEAVE_DET:  code = CODE_LEAVE_DET;
            PH_ENTER_DONE: code = CODE_ENTER_DONE;
            PH_LEAVE_DONE: code = CODE_LEAVE_DONE;
            default:       code = CODE_IDLE;
        endcase
        return code;
    endfunction

    // Near: a real echo below the threshold, compared as signed values.
    function automatic logic is_near(input logic signed [DIST_W-1:0] d,
                                     input logic [THR_W-1:0] thr);
        logic signed [DIST_W:0] d_ext;
        logic signed [DIST_W:0] t_ext;
        d_ext = signed'({d[DIST_W-1], d});
        t_ext = signed'({{(DIST_W + 1 - THR_W){1'b0}}, thr});
        return (d != NO_ECHO) && (d_ext < t_ext);
    endfunction

    // Clear: no echo, or an echo beyond the threshold.
    function automatic logic is_clear(input logic signed [DIST_W-1:0] d,
                                      input logic [THR_W-1:0] thr);
        logic signed [DIST_W:0] d_ext;
        logic signed [DIST_W:0] t_ext;
        d_ext = signed'({d[DIST_W-1], d});
        t_ext = signed'({{(DIST_W + 1 - THR_W){1'b0}}, thr});
        return (d == NO_ECHO) || (d_ext > t_ext);
    endfunction

endpackage

`default_nettype wire

// ===== src/bidirectional_occupancy_counter_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bidirectional occupancy counter.
//
// Sensor samples arrive as words on the s_axis channel: entry and exit
// distances, the heat-camera frame level and a millisecond timestamp. Each
// accepted word yields exactly one result word on the m_axis channel with the
// people count, the detection phase and the entered, exited and underflow
// flags for that sample.
// The three thresholds are written through the cfg channel, which is always
// ready; writes are only expected while no sample is in flight.
// A sample is registered in the input register on acceptance, runs through
// the phase logic and lands in the result register. One word per cycle is
// accepted while the receiver keeps taking results; the phase, count,
// mark-time and presence registers are updated as each sample leaves the
// input register.
// When the receiver stalls, the result register holds its word and the input
// register holds one more sample; s_axis_tready falls only when both are
// full. Reset empties both stages, clears the count and phase to idle and
// loads the threshold registers with their default values.

module bidirectional_occupancy_counter_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Sample channel.
    input  wire logic                               s_axis_tvalid,
    output      logic                               s_axis_tready,
    // tdata, from bit 0: enter_dist[9:0], leave_dist[9:0], ir_level[15:0],
    // now_ms[31:0], four zero pad bits.
    input  wire logic [boc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Result channel.
    output      logic                               m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tdata, from bit 0: occupancy[15:0], phase[2:0], entered, exited,
    // underflow_error, two zero pad bits.
    output      logic [boc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // Configuration write channel.
    input  wire logic                               i_cfg_valid,
    output      logic                               o_cfg_ready,
    input  wire logic [boc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [boc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import boc_pkg::*;

    // Configuration registers.
    t_cfg    r_cfg;

    // Input stage.
    t_sample r_in;
    logic    r_in_valid;

    // Block state carried from sample to sample.
    t_state  r_state;
    t_state  n_state;

    // Result stage.
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;

    logic    w_advance;
    logic    w_in_take;

    // The input stage moves on whenever the result register is empty or
    // being emptied in this cycle.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_take     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dist_thr <= DIST_THR_RST;
            r_cfg.pres_thr <= PRES_THR_RST;
            r_cfg.timeout  <= TIMEOUT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DIST_THR: r_cfg.dist_thr <= i_cfg_data[THR_W-1:0];
                CFG_PRES_THR: r_cfg.pres_thr <= signed'(i_cfg_data[LEVEL_W-1:0]);
                CFG_TIMEOUT:  r_cfg.timeout  <= i_cfg_data[TMO_W-1:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= t_sample'(s_axis_tdata[$bits(t_sample)-1:0]);
        end
    end

    boc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_sample (r_in),
        .o_state  (n_state),
        .o_result (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= PH_IDLE;
            r_state.count    <= '0;
            r_state.mark     <= '0;
            r_state.presence <= 1'b0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

    // At most one of the three event flags is raised by any sample.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> $countones({r_out.entered, r_out.exited,
                                    r_out.underflow_error}) <= 1)
        else $error("more than one event flag in a result word");

    // A released passage always leaves the machine idle.
    a_event_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.entered || r_out.exited || r_out.underflow_error))
            |-> r_out.phase == CODE_IDLE)
        else $error("event flagged without a return to idle");

    // The count only moves when a sample is processed.
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_advance |=> $stable(r_state.count))
        else $error("count changed without a sample");

    // An exit takes exactly one person off the count.
    a_exit_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_out.exited) |=> r_state.count == $past(r_state.count) - 1'b1)
        else $error("exit did not decrement the count");

    // An underflow is reported only with an empty room.
    a_uerr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.underflow_error) |-> r_out.occupancy == '0)
        else $error("underflow reported with a non-zero count");

endmodule

`default_nettype wire

// ===== src/boc_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module boc_step (
    input  wire boc_pkg::t_cfg    i_cfg,
    input  wire boc_pkg::t_state  i_state,
    input  wire boc_pkg::t_sample i_sample,
    output boc_pkg::t_state       o_state,
    output boc_pkg::t_result      o_result
);
    import boc_pkg::*;

    logic [TIME_BITS-1:0] w_elapsed;
    logic                 w_presence;
    logic                 w_timed_out;
    logic [31:0]          w_count_wide;
    t_state               w_next;
    logic                 w_entered;
    logic                 w_exited;
    logic                 w_uerr;

    assign w_elapsed   = i_sample.now_ms[TIME_BITS-1:0] - i_state.mark;
    assign w_timed_out = w_elapsed > TIME_BITS'(i_cfg.timeout);
    assign w_presence  = i_state.presence || (i_sample.ir_level > i_cfg.pres_thr);

    always_comb begin
        w_next    = i_state;
        w_entered = 1'b0;
        w_exited  = 1'b0;
        w_uerr    = 1'b0;
        case (i_state.phase)
            PH_ENTER_DET, PH_LEAVE_DET: begin
                // Presence is latched from this sample before the timeout test.
                w_next.presence = w_presence;
                if (w_timed_out) begin
                    w_next.phase = PH_IDLE;
                end else if (w_presence) begin
                    if (i_state.phase == PH_ENTER_DET &&
                        is_near(i_sample.leave_dist, i_cfg.dist_thr)) begin
                        w_next.phase = PH_ENTER_DONE;
                    end else if (i_state.phase == PH_LEAVE_DET &&
                                 is_near(i_sample.enter_dist, i_cfg.dist_thr)) begin
                        w_next.phase = PH_LEAVE_DONE;
                    end
                end
            end
            PH_ENTER_DONE: begin
                if (is_clear(i_sample.leave_dist, i_cfg.dist_thr)) begin
                    if (i_state.count != COUNT_MAX) begin
                        w_next.count = i_state.count + 1'b1;
                    end
                    w_entered    = 1'b1;
                    w_next.phase = PH_IDLE;
                end
            end
            PH_LEAVE_DONE: begin
                if (i_state.count != '0) begin
                    if (is_clear(i_sample.enter_dist, i_cfg.dist_thr)) begin
                        w_next.count = i_state.count - 1'b1;
                        w_exited     = 1'b1;
                        w_next.phase = PH_IDLE;
                    end
                end else begin
                    w_uerr       = 1'b1;
                    w_next.phase = PH_IDLE;
                end
            end
            default: begin
                // Idle: the entry side wins when both sides read near.
                w_next.phase    = PH_IDLE;
                w_next.presence = 1'b0;
                if (is_near(i_sample.enter_dist, i_cfg.dist_thr)) begin
                    w_next.phase = PH_ENTER_DET;
                    w_next.mark  = i_sample.now_ms[TIME_BITS-1:0];
                end else if (is_near(i_sample.leave_dist, i_cfg.dist_thr)) begin
                    w_next.phase = PH_LEAVE_DET;
                    w_next.mark  = i_sample.now_ms[TIME_BITS-1:0];
                end
            end
        endcase
    end

    assign w_count_wide = 32'(w_next.count);

    assign o_state                  = w_next;
    assign o_result.occupancy       = w_count_wide[OCC_W-1:0];
    assign o_result.phase           = phase_code(w_next.phase);
    assign o_result.entered         = w_entered;
    assign o_result.exited          = w_exited;
    assign o_result.underflow_error = w_uerr;

endmodule

`default_nettype wire

// ===== dv/tb_bidirectional_occupancy_counter_unit.sv =====
`timescale 1ns / 1ps

module tb_bidirectional_occupancy_counter_unit;

    import boc_pkg::*;

    // The fourth register index is unused; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int DIR_ROWS = 24;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    bidirectional_occupancy_counter_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // One row of the directed table. Where chk is set, want is the report
    // read straight off the behaviour; elsewhere the tracker decides.
    typedef struct packed {
        logic signed [DIST_W-1:0]  ed;
        logic signed [DIST_W-1:0]  ld;
        logic signed [LEVEL_W-1:0] ir;
        logic [NOW_W-1:0]          now;
        bit                        chk;
        t_result                   want;
    } dir_row_t;

    dir_row_t dir_rows [DIR_ROWS];

    // Tracked copy of the doorway state and of the threshold registers.
    logic [PHASE_W-1:0]         door_phase;
    logic [COUNT_BITS-1:0]      door_count;
    logic [TIME_BITS-1:0]       door_mark;
    logic                       door_warm;
    logic [THR_W-1:0]           cfg_dist_thr;
    logic signed [LEVEL_W-1:0]  cfg_warm_thr;
    logic [TMO_W-1:0]           cfg_timeout;

    // Reports still owed by the block, oldest first.
    t_result door_reports [$];
    t_result seen_rep;
    t_result want_rep;
    int unsigned bad_reports;

    // Sender and receiver pacing.
    int unsigned words_sent;
    int unsigned burst_left;
    bit          rush;
    int unsigned rx_mode;
    int unsigned rx_left;
    int unsigned rx_hold;
    int unsigned rx_tick;
    logic [NOW_W-1:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Safety net: a correct run finishes in well under a millisecond.
    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic dist_near(input logic signed [DIST_W-1:0] d);
        return (d != NO_ECHO) && (int'($signed(d)) < int'(cfg_dist_thr));
    endfunction

    function automatic logic dist_clear(input logic signed [DIST_W-1:0] d);
        return (d == NO_ECHO) || (int'($signed(d)) > int'(cfg_dist_thr));
    endfunction

    // Advances the tracked doorway by one sample and returns its report.
    function automatic t_result doorway_step(input t_sample s);
        t_result r;
        logic [TIME_BITS-1:0] gap_ms;
        r = '0;
        case (door_phase)
            CODE_ENTER_DET, CODE_LEAVE_DET: begin
                if ($signed(s.ir_level) > $signed(cfg_warm_thr))
                    door_warm = 1'b1;
                gap_ms = s.now_ms - door_mark;
                if (gap_ms > TIME_BITS'(cfg_timeout)) begin
                    door_phase = CODE_IDLE;
                end else if (door_warm) begin
                    if (door_phase == CODE_ENTER_DET && dist_near(s.leave_dist))
                        door_phase = CODE_ENTER_DONE;
                    else if (door_phase == CODE_LEAVE_DET && dist_near(s.enter_dist))
                        door_phase = CODE_LEAVE_DONE;
                end
            end
            CODE_ENTER_DONE: begin
                if (dist_clear(s.leave_dist)) begin
                    if (door_count != COUNT_MAX)
                        door_count = door_count + 1'b1;
                    r.entered  = 1'b1;
                    door_phase = CODE_IDLE;
                end
            end
            CODE_LEAVE_DONE: begin
                if (door_count != '0) begin
                    if (dist_clear(s.enter_dist)) begin
                        door_count = door_count - 1'b1;
                        r.exited   = 1'b1;
                        door_phase = CODE_IDLE;
                    end
                end else begin
                    r.underflow_error = 1'b1;
                    door_phase        = CODE_IDLE;
                end
            end
            default: begin
                door_phase = CODE_IDLE;
                door_warm  = 1'b0;
                if (dist_near(s.enter_dist)) begin
                    door_phase = CODE_ENTER_DET;
                    door_mark  = s.now_ms;
                end else if (dist_near(s.leave_dist)) begin
                    door_phase = CODE_LEAVE_DET;
                    door_mark  = s.now_ms;
                end
            end
        endcase
        r.occupancy = door_count;
        r.phase     = door_phase;
        return r;
    endfunction

    function automatic t_sample mk(input logic signed [DIST_W-1:0] ed,
                                   input logic signed [DIST_W-1:0] ld,
                                   input logic signed [LEVEL_W-1:0] ir,
                                   input logic [NOW_W-1:0] now);
        t_sample s;
        s.enter_dist = ed;
        s.leave_dist = ld;
        s.ir_level   = ir;
        s.now_ms     = now;
        return s;
    endfunction

    function automatic dir_row_t row(input logic signed [DIST_W-1:0] ed,
                                     input logic signed [DIST_W-1:0] ld,
                                     input logic signed [LEVEL_W-1:0] ir,
                                     input logic [NOW_W-1:0] now,
                                     input bit chk,
                                     input logic [OCC_W-1:0] occ,
                                     input logic [PHASE_W-1:0] ph,
                                     input logic ent,
                                     input logic ext,
                                     input logic uerr);
        dir_row_t d;
        d.ed                   = ed;
        d.ld                   = ld;
        d.ir                   = ir;
        d.now                  = now;
        d.chk                  = chk;
        d.want.occupancy       = occ;
        d.want.phase           = ph;
        d.want.entered         = ent;
        d.want.exited          = ext;
        d.want.underflow_error = uerr;
        return d;
    endfunction

    function automatic logic [NOW_W-1:0] tick(input int unsigned step);
        clock_ms = clock_ms + step;
        return clock_ms;
    endfunction

    // Distance generators relative to the current threshold.
    function automatic logic signed [DIST_W-1:0] near_dist();
        if (cfg_dist_thr == '0 || $urandom_range(0, 5) == 0)
            return DIST_W'(0 - int'($urandom_range(2, 512)));
        return DIST_W'($urandom_range(0, int'(cfg_dist_thr) - 1));
    endfunction

    function automatic logic signed [DIST_W-1:0] far_dist();
        if (cfg_dist_thr >= 9'd511 || $urandom_range(0, 2) == 0)
            return NO_ECHO;
        return DIST_W'($urandom_range(int'(cfg_dist_thr) + 1, 511));
    endfunction

    function automatic logic signed [DIST_W-1:0] any_dist();
        return DIST_W'($urandom());
    endfunction

    function automatic logic signed [LEVEL_W-1:0] any_level();
        return LEVEL_W'($urandom());
    endfunction

    // A level that latches presence, where the threshold allows one.
    function automatic logic signed [LEVEL_W-1:0] warm_level();
        int lo;
        lo = int'(cfg_warm_thr) + 1;
        if (lo > 32767)
            return LEVEL_W'(32767);
        return LEVEL_W'(lo + int'($urandom_range(0, 32767 - lo)));
    endfunction

    // Puts the trigger-side distance on the entry side for an inward walk and
    // on the exit side for an outward one.
    function automatic t_sample side(input bit inward,
                                     input logic signed [DIST_W-1:0] trig,
                                     input logic signed [DIST_W-1:0] other,
                                     input logic signed [LEVEL_W-1:0] ir,
                                     input logic [NOW_W-1:0] now);
        if (inward)
            return mk(trig, other, ir, now);
        return mk(other, trig, ir, now);
    endfunction

    // Offers one sample word, pacing the sender in bursts, and records what
    // the block owes for it once the word is taken. Called at a falling edge
    // and returns at a falling edge with tvalid still high.
    task automatic offer(input t_sample s, input bit chk = 1'b0,
                         input t_result want = '0);
        t_result r;
        if (!rush && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tdata  <= IN_DATA_W'(s);
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        r = doorway_step(s);
        door_reports.push_back(chk ? want : r);
        words_sent++;
        if (burst_left != 0)
            burst_left--;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every owed report has arrived, then lets the
    // two pipeline stages settle.
    task automatic wait_for_reports();
        s_axis_tvalid <= 1'b0;
        while (door_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        wait_for_reports();
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_DIST_THR: cfg_dist_thr = data[THR_W-1:0];
            CFG_PRES_THR: cfg_warm_thr = data;
            CFG_TIMEOUT:  cfg_timeout  = data;
            default:      ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // A person walking through: trigger on one side, some waiting, a warm
    // frame with the far side near, some dwelling, then the far side clears.
    task automatic walk_passage(input bit inward);
        offer(side(inward, near_dist(), far_dist(), any_level(),
                   tick($urandom_range(0, 60))));
        repeat ($urandom_range(0, 2))
            offer(side(inward, any_dist(), far_dist(), any_level(),
                       tick($urandom_range(0, 60))));
        offer(side(inward, any_dist(), near_dist(), warm_level(),
                   tick($urandom_range(0, 60))));
        repeat ($urandom_range(0, 2))
            offer(side(inward, any_dist(),
                       $urandom_range(0, 1) ? near_dist() : DIST_W'(cfg_dist_thr),
                       any_level(), tick($urandom_range(0, 60))));
        offer(side(inward, any_dist(), far_dist(), any_level(),
                   tick($urandom_range(0, 60))));
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned pick;
        bit inward;
        stop_at = words_sent + n;
        while (words_sent < stop_at) begin
            pick   = $urandom_range(0, 9);
            inward = $urandom_range(0, 1);
            if (pick <= 3) begin
                walk_passage(1'b1);
            end else if (pick <= 6) begin
                walk_passage(1'b0);
            end else if (pick == 7) begin
                // Somebody turns back: the detect phase must time out.
                offer(side(inward, near_dist(), far_dist(), any_level(),
                           tick($urandom_range(0, 60))));
                offer(side(inward, any_dist(), near_dist(), warm_level(),
                           tick(int'(cfg_timeout) + 1 + $urandom_range(0, 1000))));
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0)
                        clock_ms = $urandom();
                    offer(mk(any_dist(), any_dist(), any_level(),
                             tick($urandom_range(0, 3000))));
                end
            end else begin
                // A passage broken off after its trigger.
                offer(side(inward, near_dist(), far_dist(), any_level(),
                           tick($urandom_range(0, 60))));
                repeat ($urandom_range(1, 3))
                    offer(mk(any_dist(), any_dist(), any_level(),
                             tick($urandom_range(0, 500))));
            end
            if ($urandom_range(0, 24) == 0)
                wait_for_reports();
        end
    endtask

    // Shortest possible entry and exit, used for full-rate traffic.
    task automatic quick_entry();
        offer(mk(10'sd0, NO_ECHO, 16'sd0, clock_ms));
        offer(mk(NO_ECHO, 10'sd0, 16'sd1, clock_ms));
        offer(mk(NO_ECHO, NO_ECHO, 16'sd0, clock_ms));
    endtask

    task automatic quick_exit();
        offer(mk(NO_ECHO, 10'sd0, 16'sd0, clock_ms));
        offer(mk(10'sd0, NO_ECHO, 16'sd1, clock_ms));
        offer(mk(NO_ECHO, NO_ECHO, 16'sd0, clock_ms));
    endtask

    // Receiver: its own stall pattern, switching at random among five modes.
    always @(negedge i_clk) begin
        if (rush) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 4);
                rx_left = $urandom_range(20, 120);
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= $urandom_range(0, 1);
                2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                3: m_axis_tready <= (rx_tick % 5 != 0);
                default: begin
                    if (rx_hold != 0) begin
                        rx_hold--;
                        m_axis_tready <= 1'b0;
                    end else if ($urandom_range(0, 15) == 0) begin
                        rx_hold = $urandom_range(5, 30);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // Every taken report word is compared against the oldest one owed.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
            seen_rep = t_result'(m_axis_tdata[$bits(t_result)-1:0]);
            if (door_reports.size() == 0) begin
                bad_reports++;
                if (bad_reports <= 10)
                    $display("unexpected report: occ %0d phase %0d ent %b ext %b uerr %b",
                             seen_rep.occupancy, seen_rep.phase, seen_rep.entered,
                             seen_rep.exited, seen_rep.underflow_error);
            end else begin
                want_rep = door_reports.pop_front();
                if (seen_rep.occupancy !== want_rep.occupancy
                        || seen_rep.phase !== want_rep.phase
                        || seen_rep.entered !== want_rep.entered
                        || seen_rep.exited !== want_rep.exited
                        || seen_rep.underflow_error !== want_rep.underflow_error) begin
                    bad_reports++;
                    if (bad_reports <= 10)
                        $display({"report mismatch: expected occ %0d phase %0d ent %b ",
                                  "ext %b uerr %b, got occ %0d phase %0d ent %b ext %b ",
                                  "uerr %b"},
                                 want_rep.occupancy, want_rep.phase, want_rep.entered,
                                 want_rep.exited, want_rep.underflow_error,
                                 seen_rep.occupancy, seen_rep.phase, seen_rep.entered,
                                 seen_rep.exited, seen_rep.underflow_error);
                end
            end
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_DIST_THR;
        i_cfg_data    = '0;
        door_phase    = CODE_IDLE;
        door_count    = '0;
        door_mark     = '0;
        door_warm     = 1'b0;
        cfg_dist_thr  = DIST_THR_RST;
        cfg_warm_thr  = PRES_THR_RST;
        cfg_timeout   = TIMEOUT_RST;
        bad_reports   = 0;
        words_sent    = 0;
        burst_left    = 0;
        rush          = 1'b0;
        rx_mode       = 0;
        rx_left       = 0;
        rx_hold       = 0;
        rx_tick       = 0;
        clock_ms      = '0;

        // Directed walk under the reset thresholds: an entry, an exit, a
        // leave with nobody inside, entry winning over exit, the timeout
        // on either side of its edge, timestamp wrap and distance extremes.
        dir_rows[0]  = row(-1, -1, 0, 0, 1, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[1]  = row(10, -1, 0, 100, 1, 0, CODE_ENTER_DET, 0, 0, 0);
        dir_rows[2]  = row(10, 10, 0, 200, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[3]  = row(-1, 10, 100, 300, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[4]  = row(-1, 50, 0, 400, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[5]  = row(-1, -1, 0, 500, 1, 1, CODE_IDLE, 1, 0, 0);
        dir_rows[6]  = row(-1, 0, 0, 1000, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[7]  = row(20, -1, 32767, 1000, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[8]  = row(400, -1, 0, 1100, 1, 0, CODE_IDLE, 0, 1, 0);
        dir_rows[9]  = row(-1, 5, 0, 2000, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[10] = row(5, -1, -32768, 2100, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[11] = row(5, -1, 1, 2200, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[12] = row(-1, -1, 0, 2300, 1, 0, CODE_IDLE, 0, 0, 1);
        dir_rows[13] = row(-2, 3, 0, 5000, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[14] = row(-1, 3, 100, 7001, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[15] = row(30, -1, 0, 10000, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[16] = row(-1, 49, 5, 12000, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[17] = row(-1, 511, 0, 12100, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[18] = row(1, -1, 0, 32'hFFFF_FF00, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[19] = row(-1, -512, 1, 32'h0000_0100, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[20] = row(-1, -1, 0, 32'h0000_0200, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[21] = row(50, 50, 0, 300, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[22] = row(-512, -1, -1, 400, 0, 0, CODE_IDLE, 0, 0, 0);
        dir_rows[23] = row(511, 511, 32767, 32'hFFFF_FFFF, 0, 0, CODE_IDLE, 0, 0, 0);

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIR_ROWS; i++)
            offer(mk(dir_rows[i].ed, dir_rows[i].ld, dir_rows[i].ir, dir_rows[i].now),
                  dir_rows[i].chk, dir_rows[i].want);

        // Tightest thresholds.
        load_register(CFG_DIST_THR, {7'($urandom()), 9'd1});
        load_register(CFG_PRES_THR, 16'h8000);
        load_register(CFG_TIMEOUT, 16'd1);
        run_random(110);

        // Wide thresholds; no frame can be warm enough to latch presence.
        load_register(CFG_DIST_THR, 16'd400);
        load_register(CFG_PRES_THR, 16'h7FFF);
        load_register(CFG_TIMEOUT, 16'hFFFF);
        run_random(70);

        // A zero timeout ends any detect phase that sees time move, and a
        // write to the unused index must leave everything alone.
        load_register(CFG_DIST_THR, 16'($urandom_range(1, 400)));
        load_register(CFG_PRES_THR, 16'($urandom()));
        load_register(CFG_TIMEOUT, 16'd0);
        load_register(CFG_SPARE, 16'($urandom()));
        run_random(70);

        // Back-to-back passages at full rate: a run of entries, then exits
        // until the room is empty and one more leave that finds it empty.
        load_register(CFG_DIST_THR, 16'd50);
        load_register(CFG_PRES_THR, 16'h0000);
        load_register(CFG_TIMEOUT, 16'hFFFF);
        rush = 1'b1;
        while (door_phase != CODE_IDLE)
            offer(mk(NO_ECHO, NO_ECHO, 16'sd0, tick(70000)));
        repeat (6) quick_entry();
        repeat (int'(door_count) + 1) quick_exit();
        rush = 1'b0;
        wait_for_reports();

        // Random settings to close.
        repeat (3) begin
            load_register(CFG_DIST_THR, 16'($urandom()));
            load_register(CFG_PRES_THR, 16'($urandom_range(0, 65535)));
            load_register(CFG_TIMEOUT, 16'($urandom_range(1, 3000)));
            run_random(90);
        end
        load_register(CFG_DIST_THR, 16'($urandom_range(1, 400)));
        load_register(CFG_PRES_THR, 16'($urandom_range(0, 200)));
        load_register(CFG_TIMEOUT, 16'($urandom_range(1, 65535)));
        run_random(40);

        wait_for_reports();
        repeat (10) @(negedge i_clk);
        if (bad_reports == 0 && door_reports.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
